/* src/fiir_pkg.sv */
// ----------------------------------------------------------------------------
// fiir_pkg
// shared types and constants of the first-order iir filter bank
// ----------------------------------------------------------------------------
package fiir_pkg;

  localparam int unsigned ChanW    = 6;
  localparam int unsigned SampleW  = 16;
  localparam int unsigned StateW   = 24;
  localparam int unsigned TdataW   = 24;
  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned CoefW    = 16;
  localparam int unsigned RamW     = SampleW + StateW;

  // gain of 1.0 in q1.15
  localparam logic [CoefW-1:0] GainOne = 16'h8000;

  localparam logic [CfgIdxW-1:0] RegMode = 8'd0;
  localparam logic [CfgIdxW-1:0] RegGain = 8'd1;

  typedef enum logic [1:0] {
    MODE_PASS = 2'd0,
    MODE_LOW  = 2'd1,
    MODE_HIGH = 2'd2,
    MODE_HOLD = 2'd3
  } mode_e;

  // live configuration, gain already clamped to 1.0
  typedef struct packed {
    mode_e            mode;
    logic [CoefW-1:0] gain;
    logic [CoefW-1:0] gain_c;
  } cfg_t;

endpackage

/* src/fiir_ram.sv */
// ----------------------------------------------------------------------------
// fiir_ram
// generic single-port-write, single-port-read ram with registered read
// ----------------------------------------------------------------------------
module fiir_ram #(
  parameter int unsigned Width = 40,
  parameter int unsigned Depth = 64,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read returns the old contents on a same-address write
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

/* src/fiir_mac.sv */
// ----------------------------------------------------------------------------
// fiir_mac
// two-stage filter update: coefficient products, then sum, round, saturate
// ----------------------------------------------------------------------------
module fiir_mac (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  fiir_pkg::cfg_t                      cfg_i,
  input  logic signed [fiir_pkg::SampleW-1:0] sample_i,
  input  logic signed [fiir_pkg::SampleW-1:0] prev_sample_i,
  input  logic signed [fiir_pkg::StateW-1:0]  prev_output_i,
  output logic signed [fiir_pkg::StateW-1:0]  y_new_o
);

  localparam int unsigned OpW   = fiir_pkg::StateW + 1;
  localparam int unsigned ProdW = fiir_pkg::CoefW + 1 + OpW;
  localparam int unsigned SumW  = ProdW + 1;
  localparam int unsigned ShW   = SumW - 15;

  localparam logic signed [ShW-1:0] YMax = ShW'(signed'(24'sh7fffff));
  localparam logic signed [ShW-1:0] YMin = ShW'(signed'(24'sh800000));

  logic [fiir_pkg::CoefW-1:0] coef_a;
  logic [fiir_pkg::CoefW-1:0] coef_b;
  logic signed [OpW-1:0]      op_a;
  logic signed [OpW-1:0]      x_ext;
  logic signed [OpW-1:0]      y_ext;
  logic signed [fiir_pkg::SampleW:0] x_diff;
  logic signed [ProdW-1:0]    prod_a_d, prod_a_q;
  logic signed [ProdW-1:0]    prod_b_d, prod_b_q;
  logic signed [SumW-1:0]     sum;
  logic signed [ShW-1:0]      sh;

  // every mode maps onto (ca*op_a + cb*y + 2^14) >> 15
  always_comb begin
    x_ext  = OpW'($signed({sample_i, 8'h00}));
    y_ext  = OpW'(prev_output_i);
    x_diff = (fiir_pkg::SampleW+1)'(sample_i) - (fiir_pkg::SampleW+1)'(prev_sample_i);
    unique case (cfg_i.mode)
      fiir_pkg::MODE_PASS: begin
        coef_a = fiir_pkg::GainOne;
        op_a   = x_ext;
        coef_b = '0;
      end
      fiir_pkg::MODE_LOW: begin
        coef_a = cfg_i.gain;
        op_a   = x_ext - y_ext;
        coef_b = fiir_pkg::GainOne;
      end
      fiir_pkg::MODE_HIGH: begin
        coef_a = cfg_i.gain_c;
        op_a   = $signed({x_diff, 8'h00});
        coef_b = cfg_i.gain;
      end
      fiir_pkg::MODE_HOLD: begin
        coef_a = '0;
        op_a   = '0;
        coef_b = fiir_pkg::GainOne;
      end
      default: begin
        coef_a = '0;
        op_a   = '0;
        coef_b = '0;
      end
    endcase
    prod_a_d = ProdW'($signed({1'b0, coef_a})) * ProdW'(op_a);
    prod_b_d = ProdW'($signed({1'b0, coef_b})) * ProdW'(y_ext);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_a_q <= prod_a_d;
      prod_b_q <= prod_b_d;
    end
  end

  always_comb begin
    sum = SumW'(prod_a_q) + SumW'(prod_b_q) + SumW'(signed'(16'sh4000));
    sh  = ShW'(sum >>> 15);
    priority if (sh > YMax) begin
      y_new_o = fiir_pkg::StateW'(YMax);
    end else if (sh < YMin) begin
      y_new_o = fiir_pkg::StateW'(YMin);
    end else begin
      y_new_o = fiir_pkg::StateW'(sh);
    end
  end

endmodule

/* src/first_order_iir_filter_bank_core.sv */
// ----------------------------------------------------------------------------
// first_order_iir_filter_bank_core
// bank of first-order pass / lowpass / highpass / hold filters, state kept in ram
// ----------------------------------------------------------------------------
// usage:
//   input stream s_axis: tdata[5:0] channel, tdata[21:6] signed sample.
//   output stream m_axis: tdata[5:0] channel, tdata[21:6] filtered sample.
//   config channel: cfg_index_i 0 writes the mode (0 pass, 1 lowpass,
//   2 highpass, 3 hold), 1 writes the q1.15 gain; other indexes are ignored.
//   one result per input transfer, in order, registered through s1, s2,
//   s3 and the output register.
//   throughput is one transfer per cycle while consecutive items name
//   different channels and the output side is not stalled; the per-channel
//   read-modify-write of the state ram interlocks, so an item for a channel
//   still in the two update stages waits.
//   after reset, and after each config write to a valid index, a clearing
//   pass zeroes the state ram one entry per cycle; no input transfer is
//   taken meanwhile, config writes always are.
//   a stalled receiver holds the output register; the pipeline stages ahead
//   of it keep filling until full, then s_axis_tready drops.
//   channels at or above CHANNELS touch no state and return zero.
// ----------------------------------------------------------------------------
module first_order_iir_filter_bank_core #(
  parameter int unsigned CHANNELS = 64
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // input stream
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [fiir_pkg::TdataW-1:0]     s_axis_tdata,  // channel, sample
  // output stream
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [fiir_pkg::TdataW-1:0]     m_axis_tdata,  // out_channel, filtered
  // configuration writes
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [fiir_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [fiir_pkg::CfgDataW-1:0]   cfg_data_i
);

  localparam int unsigned AddrW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [AddrW-1:0] ClrLast = AddrW'(CHANNELS - 1);
  localparam int unsigned ChW = fiir_pkg::ChanW;
  localparam int unsigned SW  = fiir_pkg::SampleW;
  localparam int unsigned YW  = fiir_pkg::StateW;

  // input fields
  logic [ChW-1:0]       in_ch;
  logic signed [SW-1:0] in_sample;
  logic                 in_range;
  logic                 hazard;
  logic                 in_xfer;
  logic                 cfg_xfer;
  logic                 cfg_hit;

  // configuration
  fiir_pkg::cfg_t cfg_d, cfg_q;

  // clearing pass
  logic             clr_busy_d, clr_busy_q;
  logic [AddrW-1:0] clr_cnt_d, clr_cnt_q;

  // pipeline: s1 ram read data, s2 products, s3 new state, out register
  logic                 v1_q, v2_q, v3_q, out_v_q;
  logic [ChW-1:0]       ch1_q, ch2_q, ch3_q, out_ch_q;
  logic signed [SW-1:0] x1_q, x2_q;
  logic                 inr1_q, inr2_q, inr3_q;
  logic signed [YW-1:0] y3_q;
  logic signed [SW-1:0] out_filt_q, out_filt_d;
  logic                 en_out, en3, en2, en1;

  // state ram
  logic                                 ram_we;
  logic [AddrW-1:0]                     ram_waddr;
  logic [fiir_pkg::RamW-1:0]            ram_wdata;
  logic [fiir_pkg::RamW-1:0]            ram_rdata;
  logic signed [SW-1:0]                 prev_sample;
  logic signed [YW-1:0]                 prev_output;
  logic signed [YW-1:0]                 y_new;
  logic                                 pipe_wr;

  // output rounding
  logic signed [YW:0]   y_rnd;
  logic signed [YW-8:0] y_sh;

  assign in_ch     = s_axis_tdata[ChW-1:0];
  assign in_sample = s_axis_tdata[ChW+SW-1:ChW];
  assign in_range  = 32'(in_ch) < 32'(CHANNELS);

  // same-channel items wait until the older one has written back
  assign hazard = (v1_q && (ch1_q == in_ch)) || (v2_q && (ch2_q == in_ch));

  // stage enables: a stage loads when the next one is free or moving
  assign en_out = !out_v_q || m_axis_tready;
  assign en3    = en_out || !v3_q;
  assign en2    = en3 || !v2_q;
  assign en1    = en2 || !v1_q;

  assign s_axis_tready = en1 && !hazard && !clr_busy_q;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  assign cfg_ready_o = 1'b1;
  assign cfg_xfer    = cfg_valid_i && cfg_ready_o;
  assign cfg_hit     = cfg_xfer &&
                       ((cfg_index_i == fiir_pkg::RegMode) ||
                        (cfg_index_i == fiir_pkg::RegGain));

  // config registers, gain clamped to 1.0 on write
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_xfer) begin
      unique case (cfg_index_i)
        fiir_pkg::RegMode: begin
          cfg_d.mode = fiir_pkg::mode_e'(cfg_data_i[1:0]);
        end
        fiir_pkg::RegGain: begin
          if (cfg_data_i > fiir_pkg::GainOne) begin
            cfg_d.gain = fiir_pkg::GainOne;
          end else begin
            cfg_d.gain = cfg_data_i;
          end
          cfg_d.gain_c = fiir_pkg::GainOne - cfg_d.gain;
        end
        default: begin
          cfg_d = cfg_q;
        end
      endcase
    end
  end

  // clearing pass, restarted by any accepted write to a valid register index
  always_comb begin
    clr_busy_d = clr_busy_q;
    clr_cnt_d  = clr_cnt_q;
    priority if (cfg_hit) begin
      clr_busy_d = 1'b1;
      clr_cnt_d  = '0;
    end else if (clr_busy_q) begin
      if (clr_cnt_q == ClrLast) begin
        clr_busy_d = 1'b0;
      end else begin
        clr_cnt_d = clr_cnt_q + AddrW'(1);
      end
    end else begin
      // idle, nothing to clear
      clr_cnt_d = clr_cnt_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode   <= fiir_pkg::MODE_PASS;
      cfg_q.gain   <= fiir_pkg::GainOne;
      cfg_q.gain_c <= '0;
      clr_busy_q   <= 1'b1;
      clr_cnt_q    <= '0;
    end else begin
      cfg_q      <= cfg_d;
      clr_busy_q <= clr_busy_d;
      clr_cnt_q  <= clr_cnt_d;
    end
  end

  // pipeline valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (en1) begin
        v1_q <= in_xfer;
      end
      if (en2) begin
        v2_q <= v1_q;
      end
      if (en3) begin
        v3_q <= v2_q;
      end
      if (en_out) begin
        out_v_q <= v3_q;
      end
    end
  end

  // pipeline payload
  always_ff @(posedge clk_i) begin
    if (en1) begin
      ch1_q  <= in_ch;
      x1_q   <= in_sample;
      inr1_q <= in_range;
    end
    if (en2) begin
      ch2_q  <= ch1_q;
      x2_q   <= x1_q;
      inr2_q <= inr1_q;
    end
    if (en3) begin
      ch3_q  <= ch2_q;
      inr3_q <= inr2_q;
      y3_q   <= y_new;
    end
    if (en_out) begin
      out_ch_q   <= ch3_q;
      out_filt_q <= out_filt_d;
    end
  end

  // write-back happens as the item leaves the product stage
  assign pipe_wr = v2_q && en3 && inr2_q;

  always_comb begin
    if (clr_busy_q) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt_q;
      ram_wdata = '0;
    end else begin
      ram_we    = pipe_wr;
      ram_waddr = AddrW'(ch2_q);
      ram_wdata = {x2_q, y_new};
    end
  end

  fiir_ram #(
    .Width (fiir_pkg::RamW),
    .Depth (CHANNELS)
  ) u_state_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (in_xfer && in_range),
    .raddr_i (AddrW'(in_ch)),
    .rdata_o (ram_rdata)
  );

  assign prev_sample = ram_rdata[fiir_pkg::RamW-1:YW];
  assign prev_output = ram_rdata[YW-1:0];

  fiir_mac u_mac (
    .clk_i         (clk_i),
    .en_i          (en2),
    .cfg_i         (cfg_q),
    .sample_i      (x1_q),
    .prev_sample_i (prev_sample),
    .prev_output_i (prev_output),
    .y_new_o       (y_new)
  );

  // q16.8 to integer, round half up, saturate to 16 bits
  always_comb begin
    y_rnd = (YW+1)'(y3_q) + (YW+1)'(signed'(9'sd128));
    y_sh  = (YW-7)'(y_rnd >>> 8);
    if (!inr3_q) begin
      out_filt_d = '0;
    end else if (y_sh > (YW-7)'(signed'(16'sh7fff))) begin
      out_filt_d = 16'sh7fff;
    end else if (y_sh < (YW-7)'(signed'(16'sh8000))) begin
      out_filt_d = 16'sh8000;
    end else begin
      out_filt_d = SW'(y_sh);
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {(fiir_pkg::TdataW - ChW - SW)'(0), out_filt_q, out_ch_q};

  // a write to a valid register index always restarts the clearing pass from entry zero
  a_cfg_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_hit |=> (clr_busy_q && (clr_cnt_q == '0)))
    else $error("clearing pass not restarted after register write");

  // interlock keeps two updates of one channel out of s1 and s2 together
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && v2_q) |-> (ch1_q != ch2_q))
    else $error("same channel in overlapping read-modify-write");

  // the clearing pass only ends after the last entry
  a_clr_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(clr_busy_q) |-> ($past(clr_cnt_q) == ClrLast))
    else $error("clearing pass ended early");

  // no input is taken while the ram is being cleared
  a_clr_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy_q |-> !s_axis_tready)
    else $error("input accepted during clearing pass");

endmodule
